/* design/bdd_pkg.sv */
// ----------------------------------------------------------------------------
// Bond detection package
// Shared constants, register indexes and the control types that pass between
// the pair checker and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bdd_pkg;

   // Default table depth
   localparam int MAX_ATOMS_DEF = 64;

   // Fixed field widths
   localparam int COORD_W    = 16;
   localparam int RADIUS_W   = 10;
   localparam int ATOM_W     = 3 * COORD_W + RADIUS_W;
   localparam int ATOM_IDX_W = 6;
   localparam int BOND_LEN_W = 13;
   localparam int TOL_W      = 10;
   localparam int LEN_SQ_W   = 2 * BOND_LEN_W;
   localparam int CSR_IDX_W  = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BOND   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BOND   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_TOL = 2'd2;

   // Register reset values: 0.4, 5.0 and 0.45 angstrom in 1/256 units
   localparam logic [BOND_LEN_W-1:0] MIN_BOND_RST   = 13'd102;
   localparam logic [BOND_LEN_W-1:0] MAX_BOND_RST   = 13'd1280;
   localparam logic [TOL_W-1:0]      RADIUS_TOL_RST = 10'd115;

   // Distance limits handed to the pair checker
   typedef struct packed {
      logic [LEN_SQ_W-1:0] min_sq;
      logic [LEN_SQ_W-1:0] max_sq;
      logic [TOL_W-1:0]    tol;
   } bdd_limits_type;

   // Status of the last pair checker stage, with a busy flag for the whole pipeline
   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic [ATOM_IDX_W-1:0] index;
      logic                  busy;
   } bdd_check_type;

endpackage

`default_nettype wire

/* design/bond_detect_by_distance.sv */
// ----------------------------------------------------------------------------
// Bond detection by interatomic distance
// Each req_ word carries one atom (position and covalent radius). The atom is
// stored in the atom table and checked against every earlier atom of the
// same molecule; every bonded pair produces one rsp_ word, with rsp_tlast on
// the final word of that atom. An atom with no partner gives one empty word,
// and an atom arriving at a full table is dropped and flagged in rsp_tuser.
// req_tuser set starts a new molecule (table emptied before storing).
// Registers are written on the csr_ channel, which is always ready; writes
// are meant for times when no atom is in flight.
// Flow: an atom stored at index k needs k table reads, one per cycle from
// the single memory read port while no stall holds the scan, plus the
// four-stage pair pipeline and the finish step that issues the last word.
// A dropped or first atom skips the scan and gives its word from the finish
// step. req_tready is high only between atoms and returns the cycle after
// the final word is loaded. A result register sits on the rsp_ side, so the
// next atom can be taken while the last word still waits. When rsp_tready
// stays low, the scan pipeline holds with one bond pending. Reset empties
// the molecule and loads the default bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module bond_detect_by_distance
   import bdd_pkg::*;
#(
   parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Atom input
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [63:0]           req_tdata,  // atom_x, atom_y, atom_z, atom_radius
   input  wire logic                  req_tuser,  // start_molecule
   // Bond results
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,  // first_atom, second_atom
   output logic                       rsp_tlast,  // last_result
   output logic [1:0]                 rsp_tuser,  // bond_found, table_full
   // Register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [BOND_LEN_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_ATOMS);
   localparam int CNT_W = $clog2(MAX_ATOMS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // Control state
   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      cur_idx_ff;
   logic [ATOM_W-1:0]     cur_atom_ff;
   logic                  full_flag_ff;
   logic                  pend_valid_ff, pend_valid_in;
   logic [ATOM_IDX_W-1:0] pend_first_ff, pend_first_in;

   // Configuration
   logic [BOND_LEN_W-1:0] min_bond_ff, max_bond_ff;
   logic [TOL_W-1:0]      radius_tol_ff;
   logic [LEN_SQ_W-1:0]   min_sq_ff, max_sq_ff;
   bdd_limits_type        limits;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  bond_ff, last_ff, full_ff;
   logic [ATOM_IDX_W-1:0] first_ff, second_ff;
   logic                  load;
   logic                  load_bond, load_last, load_full;
   logic [ATOM_IDX_W-1:0] load_first, load_second;

   // Datapath hookup
   logic                  accept;
   logic [CNT_W-1:0]      base_cnt;
   logic                  table_is_full;
   logic                  out_free;
   logic                  issue;
   logic                  adv;
   logic                  stall;
   logic [ATOM_W-1:0]     rd_data;
   bdd_check_type         check;

   assign csr_ready = 1'b1;

   // Configuration registers; out-of-range indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         min_bond_ff   <= MIN_BOND_RST;
         max_bond_ff   <= MAX_BOND_RST;
         radius_tol_ff <= RADIUS_TOL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_BOND:   min_bond_ff   <= csr_wdata;
            CSR_MAX_BOND:   max_bond_ff   <= csr_wdata;
            CSR_RADIUS_TOL: radius_tol_ff <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Squared distance bounds follow the registers in the next cycle.
   always_ff @(posedge clock) begin
      min_sq_ff <= LEN_SQ_W'(min_bond_ff) * LEN_SQ_W'(min_bond_ff);
      max_sq_ff <= LEN_SQ_W'(max_bond_ff) * LEN_SQ_W'(max_bond_ff);
   end

   always_comb begin
      limits.min_sq = min_sq_ff;
      limits.max_sq = max_sq_ff;
      limits.tol    = radius_tol_ff;
   end

   // Input acceptance and table slot
   assign req_tready    = (state_ff == ST_IDLE);
   assign accept        = req_tvalid && req_tready;
   assign base_cnt      = req_tuser ? '0 : count_ff;
   assign table_is_full = base_cnt >= CNT_W'(MAX_ATOMS);
   assign out_free      = !rsp_valid_ff || rsp_tready;

   // The scan reads only entries below the new atom, which was written when
   // it was accepted, so a read never meets a pending write to the same entry.
   assign issue = (state_ff == ST_SCAN) && (rd_ptr_ff != cur_idx_ff);
   assign stall = check.valid && check.hit && pend_valid_ff && !out_free;
   assign adv   = !stall;

   bdd_atom_ram #(
      .DEPTH  (MAX_ATOMS),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept && !table_is_full),
      .wr_addr (base_cnt[IDX_W-1:0]),
      .wr_data (req_tdata[ATOM_W-1:0]),
      .rd_en   (adv && issue),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   bdd_pair_check u_check (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .issue     (issue),
      .issue_idx (ATOM_IDX_W'(rd_ptr_ff[IDX_W-1:0])),
      .rd_data   (rd_data),
      .cur_atom  (cur_atom_ff),
      .limits    (limits),
      .status    (check)
   );

   // Sequencer, pending bond and result loading
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      pend_valid_in = pend_valid_ff;
      pend_first_in = pend_first_ff;
      load          = 1'b0;
      load_bond     = 1'b0;
      load_first    = '0;
      load_second   = '0;
      load_last     = 1'b0;
      load_full     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_valid_in = 1'b0;
               rd_ptr_in     = '0;
               if (table_is_full) begin
                  count_in = base_cnt;
                  state_in = ST_FINISH;
               end else begin
                  count_in = base_cnt + CNT_W'(1);
                  state_in = (base_cnt == '0) ? ST_FINISH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (adv && issue) begin
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            end
            // A new bond pushes the held one out; the newest one is kept
            // back so that it can carry the last-word mark.
            if (check.valid && check.hit && adv) begin
               if (pend_valid_ff) begin
                  load        = 1'b1;
                  load_bond   = 1'b1;
                  load_first  = pend_first_ff;
                  load_second = ATOM_IDX_W'(cur_idx_ff[IDX_W-1:0]);
               end
               pend_valid_in = 1'b1;
               pend_first_in = check.index;
            end
            if (!issue && !check.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               load      = 1'b1;
               load_last = 1'b1;
               if (pend_valid_ff) begin
                  load_bond   = 1'b1;
                  load_first  = pend_first_ff;
                  load_second = ATOM_IDX_W'(cur_idx_ff[IDX_W-1:0]);
               end else begin
                  load_full = full_flag_ff;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_ptr_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_ptr_ff     <= rd_ptr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_first_ff <= pend_first_in;
      if (accept) begin
         cur_atom_ff  <= req_tdata[ATOM_W-1:0];
         cur_idx_ff   <= base_cnt;
         full_flag_ff <= table_is_full;
      end
      if (load) begin
         bond_ff   <= load_bond;
         first_ff  <= load_first;
         second_ff <= load_second;
         last_ff   <= load_last;
         full_ff   <= load_full;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, second_ff, first_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {full_ff, bond_ff};

`ifndef ASSERT_OFF
   // A dropped atom gives a single empty word.
   ap_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && full_ff |-> last_ff && !bond_ff)
      else $error("table-full word is not a final empty word");

   // The earlier atom of a pair always has the lower index.
   ap_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && bond_ff |-> first_ff < second_ff)
      else $error("bond pair out of order");

   // The fill count never passes the table depth.
   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ATOMS))
      else $error("atom count beyond table depth");

   // A new atom is only taken once the previous scan has fully drained.
   ap_drained: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !check.busy && !pend_valid_ff)
      else $error("atom accepted while a scan is in flight");
`endif

endmodule

`default_nettype wire

/* design/bdd_atom_ram.sv */
// ----------------------------------------------------------------------------
// Atom table memory
// One write port and one read port; read data is registered and holds while
// the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_atom_ram
   import bdd_pkg::*;
#(
   parameter int DEPTH  = MAX_ATOMS_DEF,
   parameter int ADDR_W = $clog2(MAX_ATOMS_DEF)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [ATOM_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [ATOM_W-1:0] rd_data
);

   logic [ATOM_W-1:0] mem [DEPTH];
   logic [ATOM_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/bdd_pair_check.sv */
// ----------------------------------------------------------------------------
// Pair distance checker
// Four-stage pipeline that tests one stored atom per word against the
// arriving atom using squared distances and squared bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_pair_check
   import bdd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  issue,
   input  wire logic [ATOM_IDX_W-1:0] issue_idx,
   input  wire logic [ATOM_W-1:0]     rd_data,
   input  wire logic [ATOM_W-1:0]     cur_atom,
   input  wire bdd_limits_type        limits,
   output bdd_check_type              status
);

   // Absolute difference of two signed coordinates
   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] n;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      n = -d;
      return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
   endfunction

   // Stage 0: tag of the word in the memory read register
   logic                  v0_ff;
   logic [ATOM_IDX_W-1:0] i0_ff;

   // Stage 1: coordinate distances and radius window
   logic                  v1_ff;
   logic [ATOM_IDX_W-1:0] i1_ff;
   logic [COORD_W-1:0]    ax1_ff, ay1_ff, az1_ff;
   logic [COORD_W-1:0]    ax1_in, ay1_in, az1_in;
   logic [11:0]           hi1_ff, hi1_in;
   logic [10:0]           lo1_ff, lo1_in;
   logic                  lo_ok1_ff, lo_ok1_in;
   logic [10:0]           rsum;

   // Stage 2: squares
   logic                  v2_ff;
   logic [ATOM_IDX_W-1:0] i2_ff;
   logic [31:0]           sqx2_ff, sqy2_ff, sqz2_ff;
   logic [23:0]           hi_sq2_ff;
   logic [21:0]           lo_sq2_ff;
   logic                  lo_ok2_ff;

   // Stage 3: bond decision
   logic                  v3_ff;
   logic [ATOM_IDX_W-1:0] i3_ff;
   logic                  hit3_ff, hit3_in;
   logic [33:0]           d2;

   // Stage 1 logic
   always_comb begin
      ax1_in    = abs_diff(rd_data[COORD_W-1:0], cur_atom[COORD_W-1:0]);
      ay1_in    = abs_diff(rd_data[2*COORD_W-1:COORD_W], cur_atom[2*COORD_W-1:COORD_W]);
      az1_in    = abs_diff(rd_data[3*COORD_W-1:2*COORD_W],
                           cur_atom[3*COORD_W-1:2*COORD_W]);
      rsum      = {1'b0, rd_data[ATOM_W-1:3*COORD_W]} +
                  {1'b0, cur_atom[ATOM_W-1:3*COORD_W]};
      hi1_in    = {1'b0, rsum} + {2'b00, limits.tol};
      lo_ok1_in = rsum >= {1'b0, limits.tol};
      lo1_in    = rsum - {1'b0, limits.tol};
   end

   // Stage 3 logic: all four bounds on the squared distance
   always_comb begin
      d2      = 34'(sqx2_ff) + 34'(sqy2_ff) + 34'(sqz2_ff);
      hit3_in = (d2 > 34'(limits.min_sq)) && (d2 < 34'(limits.max_sq)) &&
                (d2 < 34'(hi_sq2_ff)) && (!lo_ok2_ff || (d2 > 34'(lo_sq2_ff)));
   end

   // Valid tags
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         i0_ff     <= issue_idx;
         i1_ff     <= i0_ff;
         ax1_ff    <= ax1_in;
         ay1_ff    <= ay1_in;
         az1_ff    <= az1_in;
         hi1_ff    <= hi1_in;
         lo1_ff    <= lo1_in;
         lo_ok1_ff <= lo_ok1_in;
         i2_ff     <= i1_ff;
         sqx2_ff   <= 32'(ax1_ff) * 32'(ax1_ff);
         sqy2_ff   <= 32'(ay1_ff) * 32'(ay1_ff);
         sqz2_ff   <= 32'(az1_ff) * 32'(az1_ff);
         hi_sq2_ff <= 24'(hi1_ff) * 24'(hi1_ff);
         lo_sq2_ff <= 22'(lo1_ff) * 22'(lo1_ff);
         lo_ok2_ff <= lo_ok1_ff;
         i3_ff     <= i2_ff;
         hit3_ff   <= hit3_in;
      end
   end

   always_comb begin
      status.valid = v3_ff;
      status.hit   = hit3_ff;
      status.index = i3_ff;
      status.busy  = v0_ff | v1_ff | v2_ff | v3_ff;
   end

endmodule

`default_nettype wire
